/* rtl/uart_rx_frame_assembler_macros.svh */
// Assertion macros used by the UART frame assembler top level.
`ifndef UART_RX_FRAME_ASSEMBLER_MACROS_SVH
`define UART_RX_FRAME_ASSEMBLER_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define URFA_ASSERT_SAME(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) else $error(msg);

// The condition must hold in the cycle after the trigger.
`define URFA_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);

`endif

/* rtl/urfa_pkg.sv */
// Package with constants, codes and types for the UART frame assembler.
`timescale 1ns / 1ps

package urfa_pkg;

	localparam int STORE_DEPTH = 128;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int BYTE_W = 8;
	localparam int IDLE_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IN_TDATA_W = 16;
	localparam int OUT_TDATA_W = 24;

	localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST = 16'd50;
	localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h68;
	localparam logic [BYTE_W-1:0] END_MARKER_RST = 8'h16;

	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_TICK = 2'd1,
		OP_RESTART = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IDLE_LIMIT = 2'd0,
		CFG_START_MARKER = 2'd1,
		CFG_END_MARKER = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [BYTE_W-1:0] wr_data;
		logic rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} store_req_t;

endpackage

/* rtl/urfa_store.sv */
// Byte store of the frame assembler: one write port and one registered read port.
`timescale 1ns / 1ps

module urfa_store (
	input logic clk,
	input urfa_pkg::store_req_t req,
	output logic [urfa_pkg::BYTE_W-1:0] rd_data
);

	logic [urfa_pkg::BYTE_W-1:0] mem [urfa_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

/* rtl/uart_rx_frame_assembler.sv */
// Top level of the UART frame assembler: request handling, frame state and result register.
//
//   channel | direction | handshake         | payload
//   s_*     | in        | s_tvalid/s_tready | opcode in tuser, rx_byte and read_index in tdata
//   m_*     | out       | m_tvalid/m_tready | frame_ready, frame_length, read_data, receive_enabled
//   cfg_*   | in        | cfg_valid/ready   | cfg_index, cfg_data
//
// Each request is held in the input register and is applied once the result register is free or taken,
// which loads the result register, making the result valid, and writes or reads the byte store.
// A new request can be taken in every cycle unless the result register is full and not taken.
// When the result register is full and not taken, the input register holds one more request.
// Reset clears the frame state and loads the register defaults; the store is not cleared.
`timescale 1ns / 1ps
`include "uart_rx_frame_assembler_macros.svh"

module uart_rx_frame_assembler (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [urfa_pkg::IN_TDATA_W-1:0] s_tdata, // rx_byte [7:0], read_index [14:8]
	input logic [1:0] s_tuser, // opcode [1:0]
	output logic m_tvalid,
	input logic m_tready,
	// frame_ready [0], frame_length [8:1], read_data [16:9], receive_enabled [17]
	output logic [urfa_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [urfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [urfa_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic v_s1;
	urfa_pkg::op_t op_s1;
	logic [urfa_pkg::BYTE_W-1:0] byte_s1;
	logic [urfa_pkg::ADDR_W-1:0] idx_s1;

	logic [urfa_pkg::IDLE_W-1:0] idle_limit_q;
	logic [urfa_pkg::BYTE_W-1:0] start_marker_q;
	logic [urfa_pkg::BYTE_W-1:0] end_marker_q;

	logic [urfa_pkg::CNT_W-1:0] fill_q;
	logic done_q;
	logic on_q;
	logic [urfa_pkg::IDLE_W-1:0] idle_q;
	logic [urfa_pkg::BYTE_W-1:0] hdr0_q;
	logic [urfa_pkg::BYTE_W-1:0] hdr1_q;
	logic [urfa_pkg::BYTE_W-1:0] hdr2_q;

	logic out_v_q;
	logic out_rd_q;

	logic proceed;
	logic [urfa_pkg::CNT_W-1:0] fill_n;
	logic done_n;
	logic on_n;
	logic [urfa_pkg::IDLE_W-1:0] idle_n;
	logic [urfa_pkg::BYTE_W-1:0] hdr0_n;
	logic [urfa_pkg::BYTE_W-1:0] hdr1_n;
	logic [urfa_pkg::BYTE_W-1:0] hdr2_n;
	logic [urfa_pkg::ADDR_W-1:0] widx;
	logic [urfa_pkg::CNT_W-1:0] fill_inc;
	logic [urfa_pkg::IDLE_W-1:0] idle_inc;
	urfa_pkg::store_req_t store_req;
	logic [urfa_pkg::BYTE_W-1:0] store_rd;

	assign proceed = v_s1 && (!out_v_q || m_tready);
	assign s_tready = !v_s1 || proceed;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= urfa_pkg::op_t'(s_tuser);
			byte_s1 <= s_tdata[7:0];
			idx_s1 <= s_tdata[14:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q <= urfa_pkg::IDLE_LIMIT_RST;
			start_marker_q <= urfa_pkg::START_MARKER_RST;
			end_marker_q <= urfa_pkg::END_MARKER_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				urfa_pkg::CFG_IDLE_LIMIT: idle_limit_q <= cfg_data;
				urfa_pkg::CFG_START_MARKER: start_marker_q <= cfg_data[7:0];
				urfa_pkg::CFG_END_MARKER: end_marker_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign widx = (fill_q >= urfa_pkg::CNT_W'(urfa_pkg::STORE_DEPTH)) ? '0
		: fill_q[urfa_pkg::ADDR_W-1:0];
	assign fill_inc = urfa_pkg::CNT_W'(widx) + urfa_pkg::CNT_W'(1);
	assign idle_inc = (idle_q == '1) ? idle_q : idle_q + urfa_pkg::IDLE_W'(1);

	always_comb begin
		fill_n = fill_q;
		done_n = done_q;
		on_n = on_q;
		idle_n = idle_q;
		hdr0_n = hdr0_q;
		hdr1_n = hdr1_q;
		hdr2_n = hdr2_q;
		store_req.wr_en = 1'b0;
		store_req.wr_addr = widx;
		store_req.wr_data = byte_s1;
		store_req.rd_en = 1'b0;
		store_req.rd_addr = idx_s1;
		case (op_s1)
			urfa_pkg::OP_BYTE: begin
				if (on_q && !done_q) begin
					store_req.wr_en = proceed;
					idle_n = '0;
					fill_n = fill_inc;
					if (widx == urfa_pkg::ADDR_W'(0)) hdr0_n = byte_s1;
					if (widx == urfa_pkg::ADDR_W'(1)) hdr1_n = byte_s1;
					if (widx == urfa_pkg::ADDR_W'(2)) hdr2_n = byte_s1;
					if (byte_s1 == end_marker_q && hdr0_n == start_marker_q
						&& {hdr1_n, hdr2_n} == 16'(fill_inc)) begin
						done_n = 1'b1;
					end
				end
			end
			urfa_pkg::OP_TICK: begin
				idle_n = idle_inc;
				if (!done_q && fill_q != '0 && idle_inc > idle_limit_q) begin
					on_n = 1'b0;
					done_n = 1'b1;
				end
			end
			urfa_pkg::OP_RESTART: begin
				fill_n = '0;
				done_n = 1'b0;
				on_n = 1'b1;
			end
			urfa_pkg::OP_READ: begin
				store_req.rd_en = proceed;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
			on_q <= 1'b1;
			idle_q <= '0;
			out_v_q <= 1'b0;
			out_rd_q <= 1'b0;
		end else begin
			if (proceed) begin
				fill_q <= fill_n;
				done_q <= done_n;
				on_q <= on_n;
				idle_q <= idle_n;
				out_rd_q <= (op_s1 == urfa_pkg::OP_READ);
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proceed) begin
			hdr0_q <= hdr0_n;
			hdr1_q <= hdr1_n;
			hdr2_q <= hdr2_n;
		end
	end

	urfa_store u_store (
		.clk (clk),
		.req (store_req),
		.rd_data (store_rd)
	);

	assign m_tvalid = out_v_q;
	assign m_tdata = {6'b0, on_q, (out_rd_q ? store_rd : 8'h00), fill_q, done_q};

	`URFA_ASSERT_SAME(a_fill_in_range, 1'b1, fill_q <= urfa_pkg::CNT_W'(urfa_pkg::STORE_DEPTH), "fill count beyond store depth")
	`URFA_ASSERT_SAME(a_off_means_done, !on_q, done_q, "reception stopped without a finished frame")
	`URFA_ASSERT_NEXT(a_restart_result, proceed && op_s1 == urfa_pkg::OP_RESTART, m_tvalid && m_tdata[8:1] == 8'd0 && m_tdata[17] && !m_tdata[0], "restart result is wrong")

endmodule
